// ----- design/dpf_pkg.sv -----
// Shared types, register map, event codes and delimiter match step for the packet framer.
`timescale 1ns / 1ps
`default_nettype none
package dpf_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 4;
  localparam int RUN_W  = 7;
  localparam int POS_W  = 6;
  localparam int PAT_W  = 64;
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 6;
  localparam int OUT_DW = 24;

  localparam logic [2:0] REG_START_PAT = 3'd0;
  localparam logic [2:0] REG_START_LEN = 3'd1;
  localparam logic [2:0] REG_END_PAT   = 3'd2;
  localparam logic [2:0] REG_END_LEN   = 3'd3;
  localparam logic [2:0] REG_BUF_SIZE  = 3'd4;

  localparam logic [RUN_W-1:0] BUF_SIZE_RST = 7'd64;

  typedef enum logic [1:0] {
    EV_START    = 2'd0,
    EV_PACKET   = 2'd1,
    EV_EMPTY    = 2'd2,
    EV_OVERFLOW = 2'd3
  } ev_kind_t;

  typedef struct packed {
    logic [PAT_W-1:0] start_pat;
    logic [LEN_W-1:0] start_len;
    logic [PAT_W-1:0] end_pat;
    logic [LEN_W-1:0] end_len;
    logic [RUN_W-1:0] buf_size;
  } cfg_t;

  typedef struct packed {
    logic start_clr;
    logic end_clr;
    logic all_clr;
  } clr_t;

  typedef struct packed {
    ev_kind_t         kind;
    logic [RUN_W-1:0] run;
  } cmd_t;

  typedef struct packed {
    logic             busy;
    logic [RUN_W-1:0] rd_idx;
  } bstat_t;

  typedef struct packed {
    logic             hit;
    logic [LEN_W-1:0] cnt;
  } match_t;

  // Naive restart match: on a mismatch the count drops to zero and the byte
  // is retried against the first delimiter byte.
  function automatic match_t match_step(input logic [LEN_W-1:0]  cnt,
                                        input logic [PAT_W-1:0]  pat,
                                        input logic [LEN_W-1:0]  len,
                                        input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] c0;
    logic [LEN_W-1:0] c1;
    logic [LEN_W-1:0] c2;
    match_t           r;
    c0 = (cnt >= len) ? '0 : cnt;
    c1 = (b != pat[{c0[2:0], 3'b000} +: BYTE_W]) ? '0 : c0;
    c2 = c1 + 4'd1;
    r.hit = 1'b0;
    r.cnt = c1;
    if (b == pat[{c1[2:0], 3'b000} +: BYTE_W]) begin
      if (c2 >= len) begin
        r.hit = 1'b1;
        r.cnt = '0;
      end else begin
        r.cnt = c2;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/dpf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/dpf_regs.sv -----
// APB-style configuration registers and their state-clear strobes.
`timescale 1ns / 1ps
`default_nettype none
module dpf_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [dpf_pkg::CFG_AW-1:0] paddr,
  input  wire logic [dpf_pkg::CFG_DW-1:0] pwdata,
  output logic      [dpf_pkg::CFG_DW-1:0] prdata,
  output dpf_pkg::cfg_t                   cfg,
  output dpf_pkg::clr_t                   clr
);

  dpf_pkg::cfg_t cfg_r;
  dpf_pkg::cfg_t cfg_nxt;
  logic          wr;
  logic [2:0]    idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[5:3];

  always_comb begin
    cfg_nxt       = cfg_r;
    clr.start_clr = 1'b0;
    clr.end_clr   = 1'b0;
    clr.all_clr   = 1'b0;
    if (wr) begin
      case (idx)
        dpf_pkg::REG_START_PAT: begin
          cfg_nxt.start_pat = pwdata;
          clr.start_clr     = 1'b1;
        end
        dpf_pkg::REG_START_LEN: begin
          cfg_nxt.start_len = pwdata[dpf_pkg::LEN_W-1:0];
          clr.start_clr     = 1'b1;
        end
        dpf_pkg::REG_END_PAT: begin
          cfg_nxt.end_pat = pwdata;
          clr.end_clr     = 1'b1;
        end
        dpf_pkg::REG_END_LEN: begin
          cfg_nxt.end_len = pwdata[dpf_pkg::LEN_W-1:0];
          clr.end_clr     = 1'b1;
        end
        dpf_pkg::REG_BUF_SIZE: begin
          cfg_nxt.buf_size = pwdata[dpf_pkg::RUN_W-1:0];
          clr.all_clr      = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_pat <= '0;
      cfg_r.start_len <= '0;
      cfg_r.end_pat   <= '0;
      cfg_r.end_len   <= '0;
      cfg_r.buf_size  <= dpf_pkg::BUF_SIZE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      dpf_pkg::REG_START_PAT: prdata = cfg_r.start_pat;
      dpf_pkg::REG_START_LEN: prdata = {{(dpf_pkg::CFG_DW-dpf_pkg::LEN_W){1'b0}}, cfg_r.start_len};
      dpf_pkg::REG_END_PAT:   prdata = cfg_r.end_pat;
      dpf_pkg::REG_END_LEN:   prdata = {{(dpf_pkg::CFG_DW-dpf_pkg::LEN_W){1'b0}}, cfg_r.end_len};
      dpf_pkg::REG_BUF_SIZE:  prdata = {{(dpf_pkg::CFG_DW-dpf_pkg::RUN_W){1'b0}}, cfg_r.buf_size};
      default:                prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- design/dpf_front.sv -----
// Front end: delimiter matching, packet store writes and event commands.
`timescale 1ns / 1ps
`default_nettype none
module dpf_front #(
  parameter int STORE_DEPTH     = 64,
  parameter int MAX_DELIM_BYTES = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [dpf_pkg::BYTE_W-1:0]       in_byte,
  input  wire dpf_pkg::cfg_t                    cfg,
  input  wire dpf_pkg::clr_t                    clr,
  input  wire dpf_pkg::bstat_t                  bstat,
  input  wire logic                             fifo_empty,
  output logic                                  ram_we,
  output logic      [$clog2(STORE_DEPTH)-1:0]   ram_waddr,
  output logic      [dpf_pkg::BYTE_W-1:0]       ram_wdata,
  output logic                                  cmd_push,
  output dpf_pkg::cmd_t                         cmd
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [dpf_pkg::LEN_W-1:0] MAX_LEN = dpf_pkg::LEN_W'(MAX_DELIM_BYTES);
  localparam logic [dpf_pkg::RUN_W-1:0] DEPTH_RUN = dpf_pkg::RUN_W'(STORE_DEPTH);

  logic [AW-1:0]               wp_r, wp_nxt;
  logic [dpf_pkg::LEN_W-1:0]   s_cnt_r, s_cnt_nxt;
  logic [dpf_pkg::LEN_W-1:0]   e_cnt_r, e_cnt_nxt;
  logic                        seen_r, seen_nxt;

  logic [dpf_pkg::LEN_W-1:0]   slen, elen;
  logic [dpf_pkg::RUN_W-1:0]   size, wp_ext, wp_inc, pkt_len;
  dpf_pkg::match_t             s_m, e_m;
  logic                        stored;

  assign slen = (cfg.start_len > MAX_LEN) ? MAX_LEN : cfg.start_len;
  assign elen = (cfg.end_len > MAX_LEN) ? MAX_LEN : cfg.end_len;
  assign size = (cfg.buf_size == '0) ? dpf_pkg::RUN_W'(1) :
                (cfg.buf_size > DEPTH_RUN) ? DEPTH_RUN : cfg.buf_size;

  assign wp_ext  = dpf_pkg::RUN_W'(wp_r);
  assign wp_inc  = wp_ext + dpf_pkg::RUN_W'(1);
  assign pkt_len = (wp_ext >= dpf_pkg::RUN_W'(elen)) ? (wp_inc - dpf_pkg::RUN_W'(elen)) : '0;

  assign s_m = dpf_pkg::match_step(s_cnt_r, cfg.start_pat, slen, in_byte);
  assign e_m = dpf_pkg::match_step(e_cnt_r, cfg.end_pat, elen, in_byte);

  // Hold off while a command waits, or while a dump still has to read the
  // entry about to be overwritten.
  assign in_ready = fifo_empty && !(bstat.busy && (bstat.rd_idx <= wp_ext));

  assign ram_waddr = wp_r;
  assign ram_wdata = in_byte;

  always_comb begin
    wp_nxt    = wp_r;
    s_cnt_nxt = s_cnt_r;
    e_cnt_nxt = e_cnt_r;
    seen_nxt  = seen_r;
    ram_we    = 1'b0;
    cmd_push  = 1'b0;
    cmd.kind  = dpf_pkg::EV_START;
    cmd.run   = '0;
    stored    = 1'b0;
    if (in_valid && in_ready) begin
      stored = 1'b1;
      if (slen != '0) begin
        s_cnt_nxt = s_m.cnt;
        if (s_m.hit) begin
          wp_nxt   = '0;
          seen_nxt = 1'b1;
          cmd_push = 1'b1;
          cmd.kind = dpf_pkg::EV_START;
          stored   = 1'b0;
        end else if (!seen_r) begin
          stored = 1'b0;
        end
      end
      if (stored) begin
        ram_we = 1'b1;
        if (elen != '0) begin
          e_cnt_nxt = e_m.cnt;
        end
        if ((elen != '0) && e_m.hit) begin
          cmd_push  = 1'b1;
          cmd.kind  = (pkt_len == '0) ? dpf_pkg::EV_EMPTY : dpf_pkg::EV_PACKET;
          cmd.run   = pkt_len;
          wp_nxt    = '0;
          s_cnt_nxt = '0;
          e_cnt_nxt = '0;
          seen_nxt  = 1'b0;
        end else if (wp_inc >= size) begin
          cmd_push = 1'b1;
          cmd.kind = dpf_pkg::EV_OVERFLOW;
          cmd.run  = size;
          wp_nxt   = '0;
        end else begin
          wp_nxt = wp_r + AW'(1);
        end
      end
    end
    if (clr.start_clr) begin
      s_cnt_nxt = '0;
      seen_nxt  = 1'b0;
    end
    if (clr.end_clr) begin
      e_cnt_nxt = '0;
    end
    if (clr.all_clr) begin
      wp_nxt    = '0;
      s_cnt_nxt = '0;
      e_cnt_nxt = '0;
      seen_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      s_cnt_r <= '0;
      e_cnt_r <= '0;
      seen_r  <= 1'b0;
    end else begin
      wp_r    <= wp_nxt;
      s_cnt_r <= s_cnt_nxt;
      e_cnt_r <= e_cnt_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/dpf_cmd_fifo.sv -----
// Two-entry command queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module dpf_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire dpf_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output dpf_pkg::cmd_t      head,
  output logic               empty,
  output logic               full
);

  dpf_pkg::cmd_t mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          do_push, do_pop;

  assign empty   = (cnt_r == 2'd0);
  assign full    = (cnt_r == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/dpf_back.sv -----
// Back end: executes commands, reads packet store and drives the result register.
`timescale 1ns / 1ps
`default_nettype none
module dpf_back #(
  parameter int STORE_DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cmd_valid,
  input  wire dpf_pkg::cmd_t                    cmd,
  output logic                                  cmd_pop,
  output logic      [$clog2(STORE_DEPTH)-1:0]   ram_raddr,
  input  wire logic [dpf_pkg::BYTE_W-1:0]       ram_rdata,
  output dpf_pkg::bstat_t                       bstat,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output dpf_pkg::ev_kind_t                     out_kind,
  output logic      [dpf_pkg::BYTE_W-1:0]       out_byte,
  output logic      [dpf_pkg::POS_W-1:0]        out_pos,
  output logic      [dpf_pkg::RUN_W-1:0]        out_run,
  output logic                                  out_last
);

  localparam int AW = $clog2(STORE_DEPTH);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_DATA = 3'b100
  } bstate_t;

  bstate_t                   state_r, state_nxt;
  dpf_pkg::ev_kind_t         kind_r, kind_nxt;
  logic [dpf_pkg::RUN_W-1:0] len_r, len_nxt;
  logic [dpf_pkg::RUN_W-1:0] idx_r, idx_nxt;
  logic [dpf_pkg::RUN_W-1:0] idx_inc;

  logic                      ov_r, ov_nxt;
  dpf_pkg::ev_kind_t         okind_r, okind_nxt;
  logic [dpf_pkg::BYTE_W-1:0] obyte_r, obyte_nxt;
  logic [dpf_pkg::POS_W-1:0] opos_r, opos_nxt;
  logic [dpf_pkg::RUN_W-1:0] orun_r, orun_nxt;
  logic                      olast_r, olast_nxt;
  logic                      out_free;

  assign out_free = !ov_r || out_ready;
  assign idx_inc  = idx_r + dpf_pkg::RUN_W'(1);

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r && !out_ready;
    okind_nxt = okind_r;
    obyte_nxt = obyte_r;
    opos_nxt  = opos_r;
    orun_nxt  = orun_r;
    olast_nxt = olast_r;
    cmd_pop   = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if ((cmd.kind == dpf_pkg::EV_START) || (cmd.kind == dpf_pkg::EV_EMPTY)) begin
            ov_nxt    = 1'b1;
            okind_nxt = cmd.kind;
            obyte_nxt = '0;
            opos_nxt  = '0;
            orun_nxt  = '0;
            olast_nxt = 1'b1;
          end else begin
            kind_nxt  = cmd.kind;
            len_nxt   = cmd.run;
            idx_nxt   = '0;
            state_nxt = B_READ;
          end
        end
      end
      B_READ: begin
        // store read of idx_r is in flight
        state_nxt = B_DATA;
      end
      B_DATA: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = kind_r;
          obyte_nxt = ram_rdata;
          opos_nxt  = idx_r[dpf_pkg::POS_W-1:0];
          orun_nxt  = len_r;
          olast_nxt = (idx_inc == len_r);
          if (idx_inc == len_r) begin
            state_nxt = B_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = B_READ;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    len_r   <= len_nxt;
    okind_r <= okind_nxt;
    obyte_r <= obyte_nxt;
    opos_r  <= opos_nxt;
    orun_r  <= orun_nxt;
    olast_r <= olast_nxt;
  end

  assign ram_raddr    = idx_r[AW-1:0];
  assign bstat.busy   = (state_r != B_IDLE);
  assign bstat.rd_idx = idx_r;

  assign out_valid = ov_r;
  assign out_kind  = okind_r;
  assign out_byte  = obyte_r;
  assign out_pos   = opos_r;
  assign out_run   = orun_r;
  assign out_last  = olast_r;

endmodule
`default_nettype wire

// ----- design/delimited_packet_framer_top.sv -----
// Delimited packet framer: top level tying front end, command queue, store and back end.
//
// Byte stream in on in_t* (one byte per transaction). Start/end delimiters
// of up to MAX_DELIM_BYTES bytes are set through the cfg_ APB port; the user
// must make writes only while the block is idle, which the block itself does
// not enforce. Results leave on out_t*: tuser is the event kind, tlast marks
// the final result caused by one input byte. Ordinary bytes are taken back
// to back while the queue is empty and no dump blocks the store write. An
// event command stalls input until the back end has popped it. A packet or
// overflow dump passes each byte through the store read (B_READ), then the
// load of the output register (B_DATA), which waits while that register
// holds a result not yet taken; input resumes as soon as the dump read
// pointer has passed the next store write position. Markers load the
// output register straight from the queue; dump bytes come from the store.
// Reset (rst_n, synchronous) clears match state, write position and queue;
// the store needs no clearing pass, since only entries written since the
// last wrap or frame boundary are ever read. When out_tready is low the
// output register holds, a command waits in the queue and in_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module delimited_packet_framer_top #(
  parameter int STORE_DEPTH     = 64,
  parameter int MAX_DELIM_BYTES = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,   // [7:0] data_byte
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // [7:0] out_byte, [13:8] byte_position, [20:14] run_length, [23:21] zero
  output logic      [dpf_pkg::OUT_DW-1:0] out_tdata,
  output logic      [1:0]                 out_tuser,  // [1:0] event_kind
  output logic                            out_tlast,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [dpf_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [dpf_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [dpf_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int AW = $clog2(STORE_DEPTH);

  dpf_pkg::cfg_t              cfg;
  dpf_pkg::clr_t              clr;
  dpf_pkg::bstat_t            bstat;
  dpf_pkg::cmd_t              push_cmd, head_cmd;
  logic                       cmd_push, cmd_pop, fifo_empty, fifo_full;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [dpf_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;
  dpf_pkg::ev_kind_t          out_kind;
  logic [dpf_pkg::BYTE_W-1:0] out_byte;
  logic [dpf_pkg::POS_W-1:0]  out_pos;
  logic [dpf_pkg::RUN_W-1:0]  out_run;

  assign cfg_pready = 1'b1;

  dpf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg),
    .clr     (clr)
  );

  dpf_front #(
    .STORE_DEPTH     (STORE_DEPTH),
    .MAX_DELIM_BYTES (MAX_DELIM_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .cfg        (cfg),
    .clr        (clr),
    .bstat      (bstat),
    .fifo_empty (fifo_empty),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .cmd_push   (cmd_push),
    .cmd        (push_cmd)
  );

  dpf_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .pop      (cmd_pop),
    .head     (head_cmd),
    .empty    (fifo_empty),
    .full     (fifo_full)
  );

  dpf_ram #(
    .WIDTH (dpf_pkg::BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  dpf_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!fifo_empty),
    .cmd       (head_cmd),
    .cmd_pop   (cmd_pop),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .bstat     (bstat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_pos   (out_pos),
    .out_run   (out_run),
    .out_last  (out_tlast)
  );

  assign out_tdata = {3'b000, out_run, out_pos, out_byte};
  assign out_tuser = out_kind;

`ifndef SYNTH
  // a command is never pushed into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !fifo_full)
    else $error("command pushed into full queue");

  // final byte of a dump sits at position run_length - 1
  a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast &&
     (out_tuser == dpf_pkg::EV_PACKET || out_tuser == dpf_pkg::EV_OVERFLOW))
    |-> ({1'b0, out_tdata[13:8]} + 7'd1 == out_tdata[20:14]))
    else $error("dump ended at wrong position");

  // store write never lands on an entry the running dump has yet to read
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && bstat.busy) |-> (bstat.rd_idx > 7'(ram_waddr)))
    else $error("store entry overwritten before dump read");
`endif

endmodule
`default_nettype wire
